// ===== rtl/mlrq_pkg.sv =====
// Shared types and fixed field widths for the multilevel priority run queue.
// No dependencies; used by every module of the block.
package mlrq_pkg;

  // Fixed widths of the stream fields.
  localparam int ACT_W  = 2;
  localparam int TID_W  = 6;
  localparam int PRIO_W = 7;
  localparam int STAT_W = 2;
  localparam int PRIO_N = 2 ** PRIO_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CHOOSE = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Write enables into the per-thread link store.
  typedef struct packed {
    logic level_we;
    logic next_we;
    logic prev_we;
  } link_we_t;

  // Write enables into the per-level head/tail table.
  typedef struct packed {
    logic head_we;
    logic tail_we;
    logic set_ne;
    logic clr_ne;
  } lvl_we_t;

endpackage

// ===== rtl/mlrq_link_store.sv =====
// Per-thread storage: recorded level, next link and prev link, one memory each.
// Registered reads with write-to-read forwarding. Depends on mlrq_pkg.
module mlrq_link_store #(
  parameter int NUM_LEVELS  = 32,
  parameter int NUM_THREADS = 64
) (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(NUM_THREADS)-1:0] rd_addr_i,
  input  mlrq_pkg::link_we_t             we_i,
  input  logic [$clog2(NUM_THREADS)-1:0] level_waddr_i,
  input  logic [$clog2(NUM_LEVELS)-1:0]  level_wdata_i,
  input  logic [$clog2(NUM_THREADS)-1:0] next_waddr_i,
  input  logic [$clog2(NUM_THREADS)-1:0] next_wdata_i,
  input  logic [$clog2(NUM_THREADS)-1:0] prev_waddr_i,
  input  logic [$clog2(NUM_THREADS)-1:0] prev_wdata_i,
  output logic [$clog2(NUM_LEVELS)-1:0]  level_o,
  output logic [$clog2(NUM_THREADS)-1:0] next_o,
  output logic [$clog2(NUM_THREADS)-1:0] prev_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int TW = $clog2(NUM_THREADS);

  logic [LW-1:0] level_mem [NUM_THREADS];
  logic [TW-1:0] next_mem  [NUM_THREADS];
  logic [TW-1:0] prev_mem  [NUM_THREADS];

  logic [LW-1:0] level_rd_q, level_fw_q;
  logic [TW-1:0] next_rd_q, next_fw_q, prev_rd_q, prev_fw_q;
  logic          level_hit_q, next_hit_q, prev_hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i.level_we) begin
      level_mem[level_waddr_i] <= level_wdata_i;
    end
    if (we_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    if (we_i.prev_we) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
  end

  // Read at accept; a write landing on the same edge is forwarded.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      level_rd_q  <= level_mem[rd_addr_i];
      next_rd_q   <= next_mem[rd_addr_i];
      prev_rd_q   <= prev_mem[rd_addr_i];
      level_hit_q <= we_i.level_we && (level_waddr_i == rd_addr_i);
      next_hit_q  <= we_i.next_we && (next_waddr_i == rd_addr_i);
      prev_hit_q  <= we_i.prev_we && (prev_waddr_i == rd_addr_i);
      level_fw_q  <= level_wdata_i;
      next_fw_q   <= next_wdata_i;
      prev_fw_q   <= prev_wdata_i;
    end
  end

  assign level_o = level_hit_q ? level_fw_q : level_rd_q;
  assign next_o  = next_hit_q ? next_fw_q : next_rd_q;
  assign prev_o  = prev_hit_q ? prev_fw_q : prev_rd_q;

endmodule

// ===== rtl/mlrq_level_table.sv =====
// Per-level head and tail registers, non-empty flags and the highest-level finder.
// Depends on mlrq_pkg.
module mlrq_level_table #(
  parameter int NUM_LEVELS  = 32,
  parameter int NUM_THREADS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [$clog2(NUM_LEVELS)-1:0]  lvl_i,
  input  mlrq_pkg::lvl_we_t              we_i,
  input  logic [$clog2(NUM_THREADS)-1:0] head_wdata_i,
  input  logic [$clog2(NUM_THREADS)-1:0] tail_wdata_i,
  output logic [$clog2(NUM_THREADS)-1:0] head_o,
  output logic [$clog2(NUM_THREADS)-1:0] tail_o,
  output logic                           nonempty_o,
  output logic                           any_o,
  output logic [$clog2(NUM_LEVELS)-1:0]  top_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int TW = $clog2(NUM_THREADS);

  logic [TW-1:0]         head_q [NUM_LEVELS];
  logic [TW-1:0]         tail_q [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ne_q;

  always_ff @(posedge clk_i) begin
    if (we_i.head_we) begin
      head_q[lvl_i] <= head_wdata_i;
    end
    if (we_i.tail_we) begin
      tail_q[lvl_i] <= tail_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
    end else if (we_i.set_ne) begin
      ne_q[lvl_i] <= 1'b1;
    end else if (we_i.clr_ne) begin
      ne_q[lvl_i] <= 1'b0;
    end
  end

  // Highest set flag wins.
  always_comb begin
    top_o = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ne_q[i]) begin
        top_o = LW'(i);
      end
    end
  end

  assign any_o      = |ne_q;
  assign head_o     = head_q[lvl_i];
  assign tail_o     = tail_q[lvl_i];
  assign nonempty_o = ne_q[lvl_i];

endmodule

// ===== rtl/multilevel_priority_run_queue_core.sv =====
// Multilevel priority run queue: one FIFO of thread ids per level, doubly linked.
// Each item passes the input register, then the result register, and waits while the result stalls.
// Throughput: one item per cycle while the result drains; the link memories read at accept, write on advance.
// Reset: clears pipeline valids, per-level non-empty flags and per-thread queued flags.
// Head/tail tables and link memories are not cleared; they are read only once written.
// Depends on mlrq_pkg, mlrq_link_store and mlrq_level_table.
module multilevel_priority_run_queue_core #(
  parameter int NUM_LEVELS      = 32,
  parameter int PRIOS_PER_LEVEL = 4,
  parameter int NUM_THREADS     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] action, [7:2] thread_id, [14:8] priority_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [5:0] chosen_thread, [7:6] status
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int TW = $clog2(NUM_THREADS);

  // Priority to level lookup, saturated at the top level.
  logic [LW-1:0] lvl_lut [mlrq_pkg::PRIO_N];

  for (genvar gi = 0; gi < mlrq_pkg::PRIO_N; gi++) begin : g_lut
    localparam int Q = gi / PRIOS_PER_LEVEL;
    assign lvl_lut[gi] = (Q >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(Q);
  end

  // Input side decode.
  logic                         in_fire;
  logic [31:0]                  in_tid32;
  logic [TW-1:0]                in_taddr;
  logic                         in_tid_ok;
  logic [mlrq_pkg::PRIO_W-1:0]  in_prio;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_tid32  = 32'(s_axis_tdata[7:2]);
  assign in_taddr  = in_tid32[TW-1:0];
  assign in_tid_ok = in_tid32 < NUM_THREADS;
  assign in_prio   = s_axis_tdata[14:8];

  // Input register stage.
  logic              s_valid_q;
  mlrq_pkg::action_e act_q;
  logic [TW-1:0]     taddr_q;
  logic              tid_ok_q;
  logic [LW-1:0]     plvl_q;

  // Result register stage.
  logic                        m_valid_q;
  logic [mlrq_pkg::TID_W-1:0]  m_chosen_q;
  mlrq_pkg::status_e           m_status_q;

  logic advance;

  // Advance the held item when the result slot is free or being drained.
  assign advance       = s_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_fire) begin
      s_valid_q <= 1'b1;
    end else if (advance) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q    <= mlrq_pkg::action_e'(s_axis_tdata[1:0]);
      taddr_q  <= in_taddr;
      tid_ok_q <= in_tid_ok;
      plvl_q   <= lvl_lut[in_prio];
    end
  end

  // Per-thread link store.
  mlrq_pkg::link_we_t link_we;
  logic [TW-1:0]      next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [LW-1:0]      rd_level;
  logic [TW-1:0]      rd_next, rd_prev;
  logic [LW-1:0]      lvl_sel;

  mlrq_link_store #(
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_THREADS (NUM_THREADS)
  ) u_link_store (
    .clk_i         (clk_i),
    .rd_en_i       (in_fire),
    .rd_addr_i     (in_taddr),
    .we_i          (link_we),
    .level_waddr_i (taddr_q),
    .level_wdata_i (lvl_sel),
    .next_waddr_i  (next_waddr),
    .next_wdata_i  (next_wdata),
    .prev_waddr_i  (prev_waddr),
    .prev_wdata_i  (prev_wdata),
    .level_o       (rd_level),
    .next_o        (rd_next),
    .prev_o        (rd_prev)
  );

  // Per-level head/tail table.
  mlrq_pkg::lvl_we_t lvl_we;
  logic [TW-1:0]     head_wdata, tail_wdata, lt_head, lt_tail;
  logic              lt_nonempty, lt_any;
  logic [LW-1:0]     lt_top;

  mlrq_level_table #(
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_THREADS (NUM_THREADS)
  ) u_level_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lvl_i        (lvl_sel),
    .we_i         (lvl_we),
    .head_wdata_i (head_wdata),
    .tail_wdata_i (tail_wdata),
    .head_o       (lt_head),
    .tail_o       (lt_tail),
    .nonempty_o   (lt_nonempty),
    .any_o        (lt_any),
    .top_o        (lt_top)
  );

  // Queued flag per thread.
  logic [NUM_THREADS-1:0] queued_q;
  logic                   q_set, q_clr, is_queued;

  assign is_queued = queued_q[taddr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
    end else if (q_set) begin
      queued_q[taddr_q] <= 1'b1;
    end else if (q_clr) begin
      queued_q[taddr_q] <= 1'b0;
    end
  end

  // Operation logic for the held item.
  logic [31:0]                 head32;
  logic                        is_head, is_tail;
  logic [mlrq_pkg::TID_W-1:0]  res_chosen;
  mlrq_pkg::status_e           res_status;

  assign head32  = 32'(lt_head);
  assign is_head = (lt_head == taddr_q);
  assign is_tail = (lt_tail == taddr_q);

  // Add works on the level of its priority, remove on the level recorded
  // when the thread was added, choose on the highest non-empty level.
  always_comb begin
    unique case (act_q)
      mlrq_pkg::ACT_ADD:    lvl_sel = plvl_q;
      mlrq_pkg::ACT_REMOVE: lvl_sel = rd_level;
      default:              lvl_sel = lt_top;
    endcase
  end

  always_comb begin
    res_chosen = '0;
    res_status = mlrq_pkg::ST_REJECT;
    link_we    = '0;
    lvl_we     = '0;
    q_set      = 1'b0;
    q_clr      = 1'b0;
    next_waddr = lt_tail;
    next_wdata = taddr_q;
    prev_waddr = taddr_q;
    prev_wdata = lt_tail;
    head_wdata = taddr_q;
    tail_wdata = taddr_q;
    unique case (act_q)
      mlrq_pkg::ACT_ADD: begin
        if (tid_ok_q && !is_queued) begin
          res_status       = mlrq_pkg::ST_OK;
          link_we.level_we = advance;
          q_set            = advance;
          lvl_we.tail_we   = advance;
          if (lt_nonempty) begin
            // Link behind the current tail.
            link_we.next_we = advance;
            link_we.prev_we = advance;
          end else begin
            lvl_we.head_we = advance;
            lvl_we.set_ne  = advance;
          end
        end
      end
      mlrq_pkg::ACT_REMOVE: begin
        if (tid_ok_q && is_queued) begin
          res_status = mlrq_pkg::ST_OK;
          q_clr      = advance;
          head_wdata = rd_next;
          tail_wdata = rd_prev;
          next_waddr = rd_prev;
          next_wdata = rd_next;
          prev_waddr = rd_next;
          prev_wdata = rd_prev;
          priority if (is_head && is_tail) begin
            lvl_we.clr_ne = advance;
          end else if (is_head) begin
            lvl_we.head_we = advance;
          end else if (is_tail) begin
            lvl_we.tail_we = advance;
          end else begin
            // Unlink from the middle: bridge prev and next.
            link_we.next_we = advance;
            link_we.prev_we = advance;
          end
        end
      end
      mlrq_pkg::ACT_CHOOSE: begin
        if (lt_any) begin
          res_status = mlrq_pkg::ST_OK;
          res_chosen = head32[mlrq_pkg::TID_W-1:0];
        end else begin
          res_status = mlrq_pkg::ST_EMPTY;
        end
      end
      default: begin
        res_status = mlrq_pkg::ST_REJECT;
      end
    endcase
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_chosen_q <= res_chosen;
      m_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_status_q, m_chosen_q};

`ifndef SYNTHESIS
  a_empty_reports_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_status_q == mlrq_pkg::ST_EMPTY) |-> (m_chosen_q == '0))
    else $error("empty result carries a nonzero thread");

  a_queued_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(queued_q) <= $countones($past(queued_q)) + 1) &&
             ($countones($past(queued_q)) <= $countones(queued_q) + 1))
    else $error("queued count moved by more than one");

  a_chosen_is_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (act_q == mlrq_pkg::ACT_CHOOSE) && lt_any |-> queued_q[lt_head])
    else $error("chosen head thread is not queued");

  a_no_write_when_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (link_we == '0) && (lvl_we == '0) && !q_set && !q_clr)
    else $error("state written without an advancing item");

  a_reject_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_status == mlrq_pkg::ST_REJECT) |=> (queued_q == $past(queued_q)))
    else $error("rejected item changed queued flags");
`endif

endmodule
